// ===== sv/mcww_pkg.sv =====
// Shared types and constants for the Markov-chain weighted walk unit.
`default_nettype none

package mcww_pkg;

    // Table geometry
    localparam int NOTE_COUNT     = 256;
    localparam int NOTE_BITS      = 8;
    localparam int MAX_EDGES      = 16;
    localparam int EDGE_IDX_BITS  = 4;
    localparam int EDGE_CNT_BITS  = EDGE_IDX_BITS + 1;
    localparam int EDGE_ADDR_BITS = NOTE_BITS + EDGE_IDX_BITS;
    localparam int EDGE_DEPTH     = NOTE_COUNT * MAX_EDGES;

    // Arithmetic widths
    localparam int WEIGHT_BITS    = 16;
    localparam int RANDOM_BITS    = 32;
    localparam int TOTAL_BITS     = WEIGHT_BITS + EDGE_IDX_BITS;
    localparam int SRC_TOTAL_BITS = NOTE_BITS + 1;
    localparam int PROD_BITS      = RANDOM_BITS + TOTAL_BITS;

    // Presence scan granularity
    localparam int CHUNK          = 16;
    localparam int CHUNK_BITS     = 4;
    localparam int CHUNK_IDX_BITS = NOTE_BITS - CHUNK_BITS;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_START = 2'd2,
        MODE_STEP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_DEAD_END = 2'd2,
        STATUS_NO_WALK  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_ADD,
        ST_STEP_CNT,
        ST_SUM,
        ST_MUL,
        ST_WALK,
        ST_CHECK,
        ST_START_MUL,
        ST_SCAN_CHUNK,
        ST_SCAN_BIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  src_note;
        logic [7:0]  dst_note;
        logic [15:0] weight;
        logic [31:0] random_word;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] note;
        logic       emitted;
        logic [1:0] status;
    } out_beat_t;

    typedef struct packed {
        logic [NOTE_BITS-1:0]   dest;
        logic [WEIGHT_BITS-1:0] weight;
    } edge_entry_t;

endpackage

`default_nettype wire

// ===== sv/markov_chain_weighted_walk_unit.sv =====
// Markov-chain weighted random walk over a note transition table.
//
// One input beat (s_valid/s_ready, s_data) carries a command; each command
// gives exactly one result beat (m_valid/m_ready, m_data). Commands: clear
// the table, add a weighted transition, start a walk at a random present
// note, or step (emit the current note and move along a weighted edge).
// The block works on one command at a time; s_ready is high only while
// the sequencer is idle, and a command may be taken while the previous
// result still waits in the output register.
// Start scans the presence map 16 notes per cycle and then one note per cycle.
// For a step, the shared accumulator walks the edge memory once to sum the
// weights, the shared 32 x 20 multiplier scales the random word, and a second
// walk finds the edge.
// Reset clears the presence map, the source count and the walk; the edge
// memories need no clearing. If the receiver stalls, the finished result
// waits in the output register and the sequencer holds before loading it.
`default_nettype none

module markov_chain_weighted_walk_unit (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  mcww_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output mcww_pkg::out_beat_t m_data
);
    import mcww_pkg::*;

    // Count set bits in one chunk of the presence map
    function automatic logic [CHUNK_BITS:0] chunk_popcount(input logic [CHUNK-1:0] bits);
        logic [CHUNK_BITS:0] sum;
        sum = '0;
        for (int i = 0; i < CHUNK; i++) begin
            sum = sum + (CHUNK_BITS+1)'(bits[i]);
        end
        return sum;
    endfunction

    state_t                    state_reg, state_next;
    mode_t                     mode_reg, mode_next;
    logic [NOTE_BITS-1:0]      idx_reg, idx_next;
    logic [NOTE_BITS-1:0]      dst_reg, dst_next;
    logic [WEIGHT_BITS-1:0]    wgt_reg, wgt_next;
    logic [RANDOM_BITS-1:0]    rnd_reg, rnd_next;
    logic [EDGE_CNT_BITS-1:0]  n_reg, n_next;
    logic [EDGE_CNT_BITS-1:0]  edge_idx_reg, edge_idx_next;
    logic [TOTAL_BITS-1:0]     acc_reg, acc_next;
    logic [TOTAL_BITS-1:0]     r_reg, r_next;
    logic [NOTE_BITS-1:0]      dest_reg, dest_next;
    logic [SRC_TOTAL_BITS-1:0] k_reg, k_next;
    logic [SRC_TOTAL_BITS-1:0] seen_reg, seen_next;
    logic [CHUNK_IDX_BITS-1:0] chunk_reg, chunk_next;
    logic [CHUNK_BITS-1:0]     bit_reg, bit_next;
    out_beat_t                 res_reg, res_next;
    out_beat_t                 m_data_reg, m_data_next;
    logic                      m_valid_reg, m_valid_next;
    logic [NOTE_COUNT-1:0]     note_present_reg, note_present_next;
    logic [SRC_TOTAL_BITS-1:0] source_total_reg, source_total_next;
    logic [NOTE_BITS-1:0]      current_note_reg, current_note_next;
    logic                      walk_started_reg, walk_started_next;

    // Edge-count and edge memories with registered reads
    logic [EDGE_CNT_BITS-1:0]  cnt_mem [NOTE_COUNT];
    logic [EDGE_CNT_BITS-1:0]  cnt_rd_reg;
    edge_entry_t               edge_mem [EDGE_DEPTH];
    edge_entry_t               edge_rd_reg;
    logic                      mem_wr_en;
    logic [EDGE_ADDR_BITS-1:0] edge_wr_addr;
    logic [EDGE_ADDR_BITS-1:0] edge_rd_addr;

    logic [EDGE_CNT_BITS-1:0]  cnt_valid;
    logic [TOTAL_BITS-1:0]     mul_b;
    logic [PROD_BITS-1:0]      product;
    logic [TOTAL_BITS-1:0]     scaled;
    logic [TOTAL_BITS-1:0]     cum;
    logic [CHUNK_BITS:0]       chunk_cnt;
    logic [SRC_TOTAL_BITS-1:0] seen_sum;
    logic                      out_free;

    // Entries of absent notes read as zero edges
    assign cnt_valid    = note_present_reg[idx_reg] ? cnt_rd_reg : '0;
    assign edge_wr_addr = {idx_reg, cnt_valid[EDGE_IDX_BITS-1:0]};
    assign edge_rd_addr = {idx_reg, edge_idx_reg[EDGE_IDX_BITS-1:0]};

    // Shared multiplier: scale the random word by a count or a weight total
    assign mul_b   = (state_reg == ST_START_MUL) ? TOTAL_BITS'(source_total_reg) : acc_reg;
    assign product = PROD_BITS'(rnd_reg) * PROD_BITS'(mul_b);
    assign scaled  = product[PROD_BITS-1 -: TOTAL_BITS];

    assign cum       = acc_reg + TOTAL_BITS'(edge_rd_reg.weight);
    assign chunk_cnt = chunk_popcount(note_present_reg[{chunk_reg, {CHUNK_BITS{1'b0}}} +: CHUNK]);
    assign seen_sum  = seen_reg + SRC_TOTAL_BITS'(chunk_cnt);
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Memories
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            cnt_mem[idx_reg]       <= cnt_valid + EDGE_CNT_BITS'(1);
            edge_mem[edge_wr_addr] <= '{dest: dst_reg, weight: wgt_reg};
        end
        cnt_rd_reg  <= cnt_mem[idx_reg];
        edge_rd_reg <= edge_mem[edge_rd_addr];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            note_present_reg <= '0;
            source_total_reg <= '0;
            current_note_reg <= '0;
            walk_started_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            m_valid_reg      <= m_valid_next;
            note_present_reg <= note_present_next;
            source_total_reg <= source_total_next;
            current_note_reg <= current_note_next;
            walk_started_reg <= walk_started_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        idx_reg      <= idx_next;
        dst_reg      <= dst_next;
        wgt_reg      <= wgt_next;
        rnd_reg      <= rnd_next;
        n_reg        <= n_next;
        edge_idx_reg <= edge_idx_next;
        acc_reg      <= acc_next;
        r_reg        <= r_next;
        dest_reg     <= dest_next;
        k_reg        <= k_next;
        seen_reg     <= seen_next;
        chunk_reg    <= chunk_next;
        bit_reg      <= bit_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    // Sequencer
    always_comb begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        idx_next          = idx_reg;
        dst_next          = dst_reg;
        wgt_next          = wgt_reg;
        rnd_next          = rnd_reg;
        n_next            = n_reg;
        edge_idx_next     = edge_idx_reg;
        acc_next          = acc_reg;
        r_next            = r_reg;
        dest_next         = dest_reg;
        k_next            = k_reg;
        seen_next         = seen_reg;
        chunk_next        = chunk_reg;
        bit_next          = bit_reg;
        res_next          = res_reg;
        m_data_next       = m_data_reg;
        note_present_next = note_present_reg;
        source_total_next = source_total_reg;
        current_note_next = current_note_reg;
        walk_started_next = walk_started_reg;
        mem_wr_en         = 1'b0;

        // Drop the result beat once taken
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next     = mode_t'(s_data.mode);
                    dst_next      = s_data.dst_note;
                    wgt_next      = s_data.weight;
                    rnd_next      = s_data.random_word;
                    edge_idx_next = '0;
                    res_next      = '{note: '0, emitted: 1'b0, status: STATUS_OK};
                    case (mode_t'(s_data.mode))
                        MODE_CLEAR: begin
                            note_present_next = '0;
                            source_total_next = '0;
                            current_note_next = '0;
                            walk_started_next = 1'b0;
                            state_next        = ST_EMIT;
                        end
                        MODE_ADD: begin
                            idx_next   = s_data.src_note;
                            state_next = ST_LOOKUP;
                        end
                        MODE_START: begin
                            if (source_total_reg == '0) begin
                                walk_started_next = 1'b0;
                                res_next.status   = STATUS_NO_WALK;
                                state_next        = ST_EMIT;
                            end else begin
                                state_next = ST_START_MUL;
                            end
                        end
                        default: begin
                            if (!walk_started_reg) begin
                                res_next.status = STATUS_NO_WALK;
                                state_next      = ST_EMIT;
                            end else begin
                                idx_next   = current_note_reg;
                                state_next = ST_LOOKUP;
                            end
                        end
                    endcase
                end
            end

            // Wait for the edge-count read
            ST_LOOKUP: begin
                state_next = (mode_reg == MODE_ADD) ? ST_ADD : ST_STEP_CNT;
            end

            // Append the edge unless the list is full
            ST_ADD: begin
                if (!note_present_reg[idx_reg]) begin
                    note_present_next[idx_reg] = 1'b1;
                    source_total_next          = source_total_reg + SRC_TOTAL_BITS'(1);
                end
                if (cnt_valid >= EDGE_CNT_BITS'(MAX_EDGES)) begin
                    res_next.status = STATUS_FULL;
                end else begin
                    mem_wr_en = 1'b1;
                end
                state_next = ST_EMIT;
            end

            ST_STEP_CNT: begin
                res_next = '{note: idx_reg, emitted: 1'b1, status: STATUS_OK};
                n_next   = cnt_valid;
                acc_next = '0;
                if (cnt_valid == '0) begin
                    res_next.status   = STATUS_DEAD_END;
                    walk_started_next = 1'b0;
                    state_next        = ST_EMIT;
                end else begin
                    edge_idx_next = EDGE_CNT_BITS'(1);
                    state_next    = ST_SUM;
                end
            end

            // Sum the weights, one edge per cycle
            ST_SUM: begin
                acc_next = cum;
                if (edge_idx_reg == n_reg) begin
                    edge_idx_next = '0;
                    state_next    = ST_MUL;
                end else begin
                    edge_idx_next = edge_idx_reg + EDGE_CNT_BITS'(1);
                end
            end

            ST_MUL: begin
                if (acc_reg == '0) begin
                    res_next.status   = STATUS_DEAD_END;
                    walk_started_next = 1'b0;
                    state_next        = ST_EMIT;
                end else begin
                    r_next        = scaled;
                    acc_next      = '0;
                    edge_idx_next = EDGE_CNT_BITS'(1);
                    state_next    = ST_WALK;
                end
            end

            // Find the first edge whose cumulative weight exceeds r
            ST_WALK: begin
                if (r_reg < cum) begin
                    dest_next  = edge_rd_reg.dest;
                    state_next = ST_CHECK;
                end else if (edge_idx_reg == n_reg) begin
                    res_next.status   = STATUS_DEAD_END;
                    walk_started_next = 1'b0;
                    state_next        = ST_EMIT;
                end else begin
                    acc_next      = cum;
                    edge_idx_next = edge_idx_reg + EDGE_CNT_BITS'(1);
                end
            end

            // Move only onto a note with an entry of its own
            ST_CHECK: begin
                if (note_present_reg[dest_reg]) begin
                    current_note_next = dest_reg;
                end else begin
                    res_next.status   = STATUS_DEAD_END;
                    walk_started_next = 1'b0;
                end
                state_next = ST_EMIT;
            end

            ST_START_MUL: begin
                k_next     = scaled[SRC_TOTAL_BITS-1:0];
                seen_next  = '0;
                chunk_next = '0;
                state_next = ST_SCAN_CHUNK;
            end

            // Skip whole chunks that lie before the k-th present note
            ST_SCAN_CHUNK: begin
                bit_next = '0;
                if (seen_sum > k_reg) begin
                    state_next = ST_SCAN_BIT;
                end else if (chunk_reg == '1) begin
                    current_note_next = '0;
                    walk_started_next = 1'b1;
                    state_next        = ST_EMIT;
                end else begin
                    seen_next  = seen_sum;
                    chunk_next = chunk_reg + CHUNK_IDX_BITS'(1);
                end
            end

            // Locate the note inside the chunk
            ST_SCAN_BIT: begin
                if (note_present_reg[{chunk_reg, bit_reg}]) begin
                    if (seen_reg == k_reg) begin
                        current_note_next = {chunk_reg, bit_reg};
                        walk_started_next = 1'b1;
                        state_next        = ST_EMIT;
                    end else begin
                        seen_next = seen_reg + SRC_TOTAL_BITS'(1);
                    end
                end
                bit_next = bit_reg + CHUNK_BITS'(1);
            end

            // Load the result beat when the output register is free
            ST_EMIT: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_total_matches_map: assert property (@(posedge aclk) disable iff (!aresetn)
        source_total_reg == SRC_TOTAL_BITS'($countones(note_present_reg)))
        else $error("source count differs from presence map");

    a_walk_on_present: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_started_reg |-> note_present_reg[current_note_reg])
        else $error("walk stands on an absent note");

    a_emit_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.emitted) |->
        (m_data.status == STATUS_OK || m_data.status == STATUS_DEAD_END))
        else $error("emitted note with a non-step status");

    a_quiet_note_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.emitted) |-> (m_data.note == '0))
        else $error("note field set without emission");
`endif

endmodule

`default_nettype wire

// ===== verif/mcww_checker.sv =====
// Scoreboard for the weighted walk unit: predicts each result beat and compares it on arrival.
`timescale 1ns / 1ps

module mcww_checker (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    input  wire                 s_ready,
    input  mcww_pkg::in_beat_t  s_data,
    input  wire                 m_valid,
    input  wire                 m_ready,
    input  mcww_pkg::out_beat_t m_data,
    output int                  fail_count,
    output int                  pending
);
    import mcww_pkg::*;

    // Shadow copy of the transition table and walk position
    logic                     note_seen [NOTE_COUNT];
    logic [EDGE_CNT_BITS-1:0] edge_cnt  [NOTE_COUNT];
    logic [NOTE_BITS-1:0]     edge_to   [EDGE_DEPTH];
    logic [WEIGHT_BITS-1:0]   edge_w    [EDGE_DEPTH];
    int unsigned              seen_total;
    logic [NOTE_BITS-1:0]     walk_note;
    bit                       walking;

    out_beat_t                result_q [$];
    out_beat_t                want;

    // Empty the table and stop the walk; edge storage is left as is
    function automatic void clear_table();
        for (int i = 0; i < NOTE_COUNT; i++) begin
            note_seen[i] = 1'b0;
            edge_cnt[i]  = '0;
        end
        seen_total = 0;
        walk_note  = '0;
        walking    = 1'b0;
    endfunction

    // floor(rnd * span / 2^RANDOM_BITS)
    function automatic logic [31:0] scale_word(logic [31:0] rnd, logic [31:0] span);
        logic [63:0] prod;
        prod = {32'd0, rnd} * {32'd0, span};
        return prod[63:RANDOM_BITS];
    endfunction

    // Apply one command to the shadow table and return the result beat it gives
    function automatic out_beat_t predict_walk(in_beat_t b);
        out_beat_t   r;
        int          base, n, seen_idx, slot;
        logic [31:0] total, cum, pick;
        logic [7:0]  nxt;
        bit          found, moved;
        r = '0;
        r.status = STATUS_OK;
        case (mode_t'(b.mode))
            MODE_CLEAR: begin
                clear_table();
            end
            MODE_ADD: begin
                if (!note_seen[b.src_note]) begin
                    note_seen[b.src_note] = 1'b1;
                    seen_total++;
                end
                if (edge_cnt[b.src_note] >= MAX_EDGES) begin
                    r.status = STATUS_FULL;
                end else begin
                    slot = int'(b.src_note) * MAX_EDGES + int'(edge_cnt[b.src_note]);
                    edge_to[slot] = b.dst_note;
                    edge_w[slot]  = b.weight;
                    edge_cnt[b.src_note] = edge_cnt[b.src_note] + 1'b1;
                end
            end
            MODE_START: begin
                if (seen_total == 0) begin
                    walking  = 1'b0;
                    r.status = STATUS_NO_WALK;
                end else begin
                    // pick the k-th present note in ascending order
                    pick      = scale_word(b.random_word, seen_total);
                    seen_idx  = 0;
                    found     = 1'b0;
                    walk_note = '0;
                    for (int i = 0; i < NOTE_COUNT; i++) begin
                        if (note_seen[i] && !found) begin
                            if (seen_idx == int'(pick)) begin
                                walk_note = i[7:0];
                                found     = 1'b1;
                            end else begin
                                seen_idx++;
                            end
                        end
                    end
                    walking = 1'b1;
                end
            end
            MODE_STEP: begin
                if (!walking) begin
                    r.status = STATUS_NO_WALK;
                end else begin
                    r.note    = walk_note;
                    r.emitted = 1'b1;
                    base  = int'(walk_note) * MAX_EDGES;
                    n     = int'(edge_cnt[walk_note]);
                    total = '0;
                    for (int e = 0; e < n; e++) total += edge_w[base + e];
                    moved = 1'b0;
                    found = 1'b0;
                    // take the first edge whose running weight passes the scaled draw
                    if (total != 0) begin
                        pick = scale_word(b.random_word, total);
                        cum  = '0;
                        for (int e = 0; e < n; e++) begin
                            if (!found) begin
                                cum += edge_w[base + e];
                                if (pick < cum) begin
                                    found = 1'b1;
                                    nxt   = edge_to[base + e];
                                    if (note_seen[nxt]) begin
                                        walk_note = nxt;
                                        moved     = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    if (!moved) begin
                        r.status = STATUS_DEAD_END;
                        walking  = 1'b0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Compare results first, then record the command taken at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_table();
            result_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected: note %0d emitted %0d status %0d",
                           m_data.note, m_data.emitted, m_data.status);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (m_data.note !== want.note) begin
                        $error("note: expected %0d, actual %0d", want.note, m_data.note);
                        fail_count++;
                    end
                    if (m_data.emitted !== want.emitted) begin
                        $error("emitted: expected %0d, actual %0d", want.emitted, m_data.emitted);
                        fail_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_data.status);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) result_q.insert(result_q.size(), predict_walk(s_data));
        end
        pending <= result_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Top level of the weighted walk unit testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import mcww_pkg::*;

    localparam int ITEM_TARGET  = 950;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 64;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        m_ready = 1'b0;
    in_beat_t    s_data  = '0;
    logic        s_ready;
    logic        m_valid;
    out_beat_t   m_data;
    int          fail_count;
    int          pending;
    logic [31:0] cycle_cnt  = '0;
    int          stall_left = 0;
    int          sent       = 0;

    // One quarter of the run goes without any idling
    wire calm = (cycle_cnt[9:8] == 2'b11);

    markov_chain_weighted_walk_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mcww_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Mostly short idle stretches, a few long ones
    function automatic int gap_len();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_weight();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 16'h0000;
        if (roll == 1) return 16'hFFFF;
        if (roll == 2) return 16'($urandom_range(1, 3));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [31:0] pick_word();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 32'h0000_0000;
        if (roll == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic in_beat_t make_cmd(mode_t m, logic [7:0] src, logic [7:0] dst,
                                          logic [15:0] w, logic [31:0] rnd);
        in_beat_t b;
        b.mode        = m;
        b.src_note    = src;
        b.dst_note    = dst;
        b.weight      = w;
        b.random_word = rnd;
        return b;
    endfunction

    // Present one command beat and hold it until the block takes it
    task automatic send_cmd(input in_beat_t b);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // Result side: random backpressure
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
        end
    end

    initial begin
        int         pool [10];
        int         pool_n, n_adds, n_walks, n_steps;
        logic [7:0] src, dst;
        logic [15:0] w;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk commands before any table exists
        send_cmd(make_cmd(MODE_STEP, 8'd0, 8'd0, 16'd0, 32'hFFFF_FFFF));
        send_cmd(make_cmd(MODE_START, 8'hFF, 8'hFF, 16'hFFFF, 32'h0));

        // Fill note 255 past its edge limit: self loop first, exit to an absent note last
        for (int i = 0; i <= MAX_EDGES; i++) begin
            dst = (i == 0) ? 8'hFF : (i == MAX_EDGES - 1) ? 8'h00 : 8'($urandom_range(1, 254));
            w   = (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom_range(1, 65535));
            send_cmd(make_cmd(MODE_ADD, 8'hFF, dst, w, $urandom));
        end
        send_cmd(make_cmd(MODE_START, 8'd0, 8'd0, 16'd0, 32'hFFFF_FFFF));
        send_cmd(make_cmd(MODE_STEP, 8'd0, 8'd0, 16'd0, 32'h0));
        send_cmd(make_cmd(MODE_STEP, 8'd0, 8'd0, 16'd0, 32'hFFFF_FFFF));
        send_cmd(make_cmd(MODE_STEP, 8'd0, 8'd0, 16'd0, $urandom));

        // Zero total weight ends the walk; then walk commands on a cleared table
        send_cmd(make_cmd(MODE_CLEAR, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_cmd(make_cmd(MODE_ADD, 8'd1, 8'd1, 16'h0000, $urandom));
        send_cmd(make_cmd(MODE_ADD, 8'd0, 8'd1, 16'hFFFF, $urandom));
        send_cmd(make_cmd(MODE_START, 8'd0, 8'd0, 16'd0, 32'h0));
        send_cmd(make_cmd(MODE_STEP, 8'd0, 8'd0, 16'd0, $urandom));
        send_cmd(make_cmd(MODE_STEP, 8'd0, 8'd0, 16'd0, $urandom));
        send_cmd(make_cmd(MODE_CLEAR, 8'd0, 8'd0, 16'd0, 32'h0));
        send_cmd(make_cmd(MODE_START, 8'd0, 8'd0, 16'd0, $urandom));

        // Random episodes: build a graph over a small note pool, then walk it
        while (sent < ITEM_TARGET) begin
            if ($urandom_range(0, 1) == 0)
                send_cmd(make_cmd(MODE_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom),
                                  $urandom));
            pool_n = $urandom_range(2, 10);
            for (int i = 0; i < pool_n; i++) pool[i] = $urandom_range(0, 255);
            n_adds = $urandom_range(pool_n, 3 * pool_n + 8);
            for (int i = 0; i < n_adds; i++) begin
                src = 8'(pool[$urandom_range(0, pool_n - 1)]);
                if ($urandom_range(0, 9) == 0) dst = 8'($urandom_range(0, 255));
                else dst = 8'(pool[$urandom_range(0, pool_n - 1)]);
                send_cmd(make_cmd(MODE_ADD, src, dst, pick_weight(), pick_word()));
            end
            n_walks = $urandom_range(1, 3);
            for (int j = 0; j < n_walks; j++) begin
                send_cmd(make_cmd(MODE_START, 8'($urandom), 8'($urandom), 16'($urandom),
                                  pick_word()));
                n_steps = $urandom_range(1, 24);
                for (int k = 0; k < n_steps; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_cmd(make_cmd(mode_t'($urandom_range(0, 3)), 8'($urandom),
                                          8'($urandom), 16'($urandom), $urandom));
                    else
                        send_cmd(make_cmd(MODE_STEP, 8'($urandom), 8'($urandom),
                                          16'($urandom), pick_word()));
                end
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding results, then allow the block to settle
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
